/* rtl/e2u_pkg.sv */
// ----------------------------------------------------------------------------
// e2u_pkg
// Shared widths, constants and the month-start table for the epoch to date
// converter.
// ----------------------------------------------------------------------------
package e2u_pkg;

  // pipeline depth, one register stage per entry
  localparam int NUM_STAGES = 7;

  // field widths
  localparam int EPOCH_W = 40;
  localparam int DAYS_W  = 22;
  localparam int SOD_W   = 17;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MDAY_W  = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int WDAY_W  = 3;
  localparam int YDAY_W  = 9;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // seconds per day split as 2^7 * 675
  localparam int DAY_SHIFT  = 7;
  localparam int DAY_QUO_W  = EPOCH_W - 1 - DAY_SHIFT;
  localparam int DAY_EST_W  = 23;
  localparam int DAY_REM_W  = 10;
  localparam int DAY_ODD    = 675;
  localparam int DAY_RCP_K  = 42;
  localparam logic [32:0] DAY_RCP =
    33'(((64'd1 << DAY_RCP_K) + 64'd674) / 64'd675);

  localparam logic [DAYS_W-1:0] LAST_DAY = 22'd2932896;
  localparam logic [SOD_W-1:0]  LAST_SEC = 17'd86399;

  // hour of day
  localparam int SECS_PER_HOUR = 3600;
  localparam int HOUR_RCP_K    = 28;
  localparam logic [16:0] HOUR_RCP =
    17'(((64'd1 << HOUR_RCP_K) + 64'd3599) / 64'd3600);

  // minute of hour
  localparam int MIN_RCP_K = 20;
  localparam logic [14:0] MIN_RCP =
    15'(((64'd1 << MIN_RCP_K) + 64'd59) / 64'd60);

  // march-based year estimate, (n * 400) / 146097 folded into one product
  localparam logic [DAYS_W-1:0] MARCH_BIAS = 22'd719468;
  localparam logic [DAYS_W-1:0] YEAR_BIAS  = 22'd719470;
  localparam int YEAR_RCP_K = 40;
  localparam logic [31:0] YEAR_RCP =
    32'(((64'd400 << YEAR_RCP_K) + 64'd146096) / 64'd146097);

  // quarter-year count divided by 25 gives the century count
  localparam int CENT_RCP_K = 20;
  localparam logic [15:0] CENT_RCP =
    16'(((64'd1 << CENT_RCP_K) + 64'd24) / 64'd25);

  // month from march-based day of year: (yd + 31) * 5 / 153
  localparam int MON_RCP_K = 20;
  localparam logic [12:0] MON_RCP =
    13'(((64'd1 << MON_RCP_K) + 64'd152) / 64'd153);

  localparam logic [YDAY_W-1:0] JAN_START = 9'd306;

  // 367 * m / 12, day offset of each march-based month
  function automatic logic [8:0] month_start(input logic [MON_W-1:0] mon);
    logic [8:0] res;
    case (mon)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd30;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd91;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd152;
      4'd6:    res = 9'd183;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd244;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd305;
      4'd11:   res = 9'd336;
      4'd12:   res = 9'd367;
      4'd13:   res = 9'd397;
      4'd14:   res = 9'd428;
      4'd15:   res = 9'd458;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/e2u_ifs.sv */
// ----------------------------------------------------------------------------
// e2u channel interfaces
// Valid/ready channels for timestamps in and calendar results out.
// ----------------------------------------------------------------------------
interface e2u_in_if;
  import e2u_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2u_out_if;
  import e2u_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  second_of_minute;
  logic [MIN_W-1:0]  minute_of_hour;
  logic [HOUR_W-1:0] hour_of_day;
  logic [MDAY_W-1:0] day_of_month;
  logic [MON_W-1:0]  month_number;
  logic [YEAR_W-1:0] full_year;
  logic [WDAY_W-1:0] weekday;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output day_of_month, output month_number,
                  output full_year, output weekday, input ready);
  modport sink   (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input day_of_month, input month_number,
                  input full_year, input weekday, output ready);
endinterface

/* rtl/e2u_day_split.sv */
// ----------------------------------------------------------------------------
// e2u_day_split
// Stages one and two: clamp, split seconds into whole days and second of day.
// ----------------------------------------------------------------------------
module e2u_day_split (
  input  logic                            clk,
  input  e2u_pkg::stage_en_t              stage_en,
  input  logic signed [e2u_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic [e2u_pkg::DAYS_W-1:0]      days,
  output logic [e2u_pkg::SOD_W-1:0]       sec_of_day
);
  import e2u_pkg::*;

  logic [EPOCH_W-2:0]   clamped;
  logic [64:0]          day_prod;
  logic [DAY_QUO_W-1:0] quo_r;
  logic [DAY_SHIFT-1:0] low_r;
  logic [DAY_EST_W-1:0] day_est_r;
  logic [31:0]          rem_full;
  logic                 saturate;
  logic [DAYS_W-1:0]    days_nxt, days_r;
  logic [SOD_W-1:0]     sod_nxt, sod_r;

  // negative inputs clamp to the epoch
  assign clamped  = epoch_seconds[EPOCH_W-1] ? '0 : epoch_seconds[EPOCH_W-2:0];
  assign day_prod = 65'(clamped[EPOCH_W-2:DAY_SHIFT]) * 65'(DAY_RCP);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      quo_r     <= clamped[EPOCH_W-2:DAY_SHIFT];
      low_r     <= clamped[DAY_SHIFT-1:0];
      day_est_r <= day_prod[64:DAY_RCP_K];
    end
  end

  assign rem_full = 32'(quo_r) - 32'(day_est_r) * 32'(DAY_ODD);
  assign saturate = day_est_r > DAY_EST_W'(LAST_DAY);

  always_comb begin
    if (saturate) begin
      days_nxt = LAST_DAY;
      sod_nxt  = LAST_SEC;
    end else begin
      days_nxt = day_est_r[DAYS_W-1:0];
      sod_nxt  = {rem_full[DAY_REM_W-1:0], low_r};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      days_r <= days_nxt;
      sod_r  <= sod_nxt;
    end
  end

  assign days       = days_r;
  assign sec_of_day = sod_r;

endmodule

/* rtl/e2u_clock.sv */
// ----------------------------------------------------------------------------
// e2u_clock
// Stages three to seven: hour, minute and second from the second of day.
// ----------------------------------------------------------------------------
module e2u_clock (
  input  logic                        clk,
  input  e2u_pkg::stage_en_t          stage_en,
  input  logic [e2u_pkg::SOD_W-1:0]   sec_of_day,
  output logic [e2u_pkg::SEC_W-1:0]   second_of_minute,
  output logic [e2u_pkg::MIN_W-1:0]   minute_of_hour,
  output logic [e2u_pkg::HOUR_W-1:0]  hour_of_day
);
  import e2u_pkg::*;

  logic [33:0]       hour_prod;
  logic [SOD_W-1:0]  sod_s3_r;
  logic [HOUR_W-1:0] hour_s3_r, hour_s4_r, hour_s5_r, hour_s6_r, hour_s7_r;
  logic [SOD_W-1:0]  remh_full;
  logic [11:0]       remh_s4_r, remh_s5_r;
  logic [26:0]       min_prod;
  logic [MIN_W-1:0]  min_s5_r, min_s6_r, min_s7_r;
  logic [11:0]       sec_full;
  logic [SEC_W-1:0]  sec_s6_r, sec_s7_r;

  assign hour_prod = 34'(sec_of_day) * 34'(HOUR_RCP);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sod_s3_r  <= sec_of_day;
      hour_s3_r <= hour_prod[HOUR_RCP_K+HOUR_W-1:HOUR_RCP_K];
    end
  end

  // seconds left within the hour
  assign remh_full = sod_s3_r - SOD_W'(hour_s3_r) * SOD_W'(SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      remh_s4_r <= remh_full[11:0];
      hour_s4_r <= hour_s3_r;
    end
  end

  assign min_prod = 27'(remh_s4_r) * 27'(MIN_RCP);

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      remh_s5_r <= remh_s4_r;
      min_s5_r  <= min_prod[MIN_RCP_K+MIN_W-1:MIN_RCP_K];
      hour_s5_r <= hour_s4_r;
    end
  end

  assign sec_full = remh_s5_r - 12'(min_s5_r) * 12'd60;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      sec_s6_r  <= sec_full[SEC_W-1:0];
      min_s6_r  <= min_s5_r;
      hour_s6_r <= hour_s5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      sec_s7_r  <= sec_s6_r;
      min_s7_r  <= min_s6_r;
      hour_s7_r <= hour_s6_r;
    end
  end

  assign second_of_minute = sec_s7_r;
  assign minute_of_hour   = min_s7_r;
  assign hour_of_day      = hour_s7_r;

endmodule

/* rtl/e2u_date.sv */
// ----------------------------------------------------------------------------
// e2u_date
// Stages three to seven: year, month, day of month and weekday from days.
// ----------------------------------------------------------------------------
module e2u_date (
  input  logic                        clk,
  input  e2u_pkg::stage_en_t          stage_en,
  input  logic [e2u_pkg::DAYS_W-1:0]  days,
  output logic [e2u_pkg::MDAY_W-1:0]  day_of_month,
  output logic [e2u_pkg::MON_W-1:0]   month_number,
  output logic [e2u_pkg::YEAR_W-1:0]  full_year,
  output logic [e2u_pkg::WDAY_W-1:0]  weekday
);
  import e2u_pkg::*;

  // stage three
  logic [DAYS_W-1:0] year_in;
  logic [53:0]       year_prod;
  logic [23:0]       wshift;
  logic [5:0]        wsum;
  logic [YEAR_W-1:0] year_s3_r;
  logic [DAYS_W-1:0] mday_s3_r;
  logic [5:0]        wsum_s3_r;
  // stage four
  logic [YEAR_W-3:0] quarters;
  logic [27:0]       cent_prod;
  logic [3:0]        wfold;
  logic [WDAY_W-1:0] wday_nxt;
  logic [YEAR_W-1:0] year_s4_r;
  logic [DAYS_W-1:0] mday_s4_r;
  logic [6:0]        cent_s4_r;
  logic [DAYS_W-1:0] ylin_s4_r;
  logic [WDAY_W-1:0] wday_s4_r;
  // stage five
  logic [DAYS_W-1:0]  base;
  logic signed [23:0] yday_raw;
  logic signed [23:0] yday_fix;
  logic               leap;
  logic [YEAR_W-1:0]  year_fix;
  logic [YDAY_W-1:0]  yday_nxt;
  logic [YEAR_W-1:0]  year_s5_r;
  logic [YDAY_W-1:0]  yday_s5_r;
  logic [WDAY_W-1:0]  wday_s5_r;
  // stage six
  logic [11:0]        mon_arg;
  logic [24:0]        mon_prod;
  logic [YEAR_W-1:0]  year_s6_r;
  logic [YDAY_W-1:0]  yday_s6_r;
  logic [MON_W-1:0]   mon_s6_r;
  logic [WDAY_W-1:0]  wday_s6_r;
  // stage seven
  logic [9:0]         mday_full;
  logic               past_jan;
  logic [MDAY_W-1:0]  mday_s7_r;
  logic [MON_W-1:0]   mon_s7_r;
  logic [YEAR_W-1:0]  year_s7_r;
  logic [WDAY_W-1:0]  wday_s7_r;

  // year estimate from days since march 1 of 1 bc
  assign year_in   = days + YEAR_BIAS;
  assign year_prod = 54'(year_in) * 54'(YEAR_RCP);

  // weekday: 8 == 1 mod 7, so octal digits add up mod 7
  assign wshift = 24'(days) + 24'd4;

  always_comb begin
    wsum = '0;
    for (int i = 0; i < 8; i++) begin
      wsum = wsum + 6'(wshift[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      year_s3_r <= year_prod[YEAR_RCP_K+YEAR_W-1:YEAR_RCP_K];
      mday_s3_r <= days + MARCH_BIAS;
      wsum_s3_r <= wsum;
    end
  end

  // century count and linear part of the year base
  assign quarters  = year_s3_r[YEAR_W-1:2];
  assign cent_prod = 28'(quarters) * 28'(CENT_RCP);
  assign wfold     = 4'(wsum_s3_r[5:3]) + 4'(wsum_s3_r[2:0]);

  always_comb begin
    if (wfold >= 4'd14) begin
      wday_nxt = WDAY_W'(wfold - 4'd14);
    end else if (wfold >= 4'd7) begin
      wday_nxt = WDAY_W'(wfold - 4'd7);
    end else begin
      wday_nxt = WDAY_W'(wfold);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      year_s4_r <= year_s3_r;
      mday_s4_r <= mday_s3_r;
      cent_s4_r <= cent_prod[CENT_RCP_K+6:CENT_RCP_K];
      ylin_s4_r <= DAYS_W'(year_s3_r) * DAYS_W'(365) + DAYS_W'(quarters);
      wday_s4_r <= wday_nxt;
    end
  end

  // day of the march year, stepping back when the estimate overshoots
  assign base     = ylin_s4_r - DAYS_W'(cent_s4_r) + DAYS_W'(cent_s4_r[6:2]);
  assign yday_raw = $signed({2'b00, mday_s4_r}) - $signed({2'b00, base});
  assign leap     = (year_s4_r[1:0] == 2'b00) &&
                    ((year_s4_r != YEAR_W'(cent_s4_r) * YEAR_W'(100)) ||
                     (cent_s4_r[1:0] == 2'b00));

  always_comb begin
    if (yday_raw < 0) begin
      yday_fix = yday_raw + 24'sd365 + $signed({23'd0, leap});
      year_fix = year_s4_r - YEAR_W'(1);
    end else begin
      yday_fix = yday_raw;
      year_fix = year_s4_r;
    end
    if (yday_fix < 0) begin
      yday_nxt = '0;
    end else begin
      yday_nxt = yday_fix[YDAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      year_s5_r <= year_fix;
      yday_s5_r <= yday_nxt;
      wday_s5_r <= wday_s4_r;
    end
  end

  // march-based month
  assign mon_arg  = 12'((12'(yday_s5_r) + 12'd31) * 12'd5);
  assign mon_prod = 25'(mon_arg) * 25'(MON_RCP);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      year_s6_r <= year_s5_r;
      yday_s6_r <= yday_s5_r;
      mon_s6_r  <= mon_prod[MON_RCP_K+MON_W-1:MON_RCP_K];
      wday_s6_r <= wday_s5_r;
    end
  end

  // back to january-based month and year
  assign mday_full = 10'(yday_s6_r) + 10'd31 - 10'(month_start(mon_s6_r));
  assign past_jan  = yday_s6_r >= JAN_START;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      mday_s7_r <= mday_full[MDAY_W-1:0];
      mon_s7_r  <= past_jan ? mon_s6_r - 4'd10 : mon_s6_r + 4'd2;
      year_s7_r <= past_jan ? year_s6_r + YEAR_W'(1) : year_s6_r;
      wday_s7_r <= wday_s6_r;
    end
  end

  assign day_of_month = mday_s7_r;
  assign month_number = mon_s7_r;
  assign full_year    = year_s7_r;
  assign weekday      = wday_s7_r;

endmodule

/* rtl/epoch_seconds_to_utc_date_core.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_core
// Seconds since 1970-01-01 UTC to broken-down Gregorian date and time.
// ----------------------------------------------------------------------------
// usage
//   in_chan carries a signed 40-bit count of seconds since the epoch; out_chan
//   returns second, minute, hour, day of month, month, year and weekday
//   (sunday is 0) for every transfer, in order
//   negative counts give 1970-01-01 00:00:00; counts past 9999-12-31 23:59:59
//   give that moment
//   an input transfer reaches valid on out_chan through the seven register
//   stages: day split (two), then year estimate, century count, year
//   correction, month and final fix-up in parallel with hour, minute and second
//   throughput is one item per cycle while out_ready is high
//   every stage has its own valid bit; a stage takes a new item when it is
//   empty or its successor moves, so bubbles close up while out_ready is low
//   and in_ready stays high until all seven stages hold an item
//   reset clears the valid bits only and holds in_ready low; the pipeline is
//   empty after reset
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_date_core (
  input  logic clk,
  input  logic rst_n,
  e2u_in_if.sink    in_chan,
  e2u_out_if.source out_chan
);
  import e2u_pkg::*;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  stage_en_t             stage_en;
  logic [DAYS_W-1:0]     days;
  logic [SOD_W-1:0]      sec_of_day;

  // stage load enables ripple back from the output
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_chan.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_nxt[0] = stage_en[0] ? in_chan.valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = stage_en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // no transfer is taken while reset is held
  assign in_chan.ready  = stage_en[0] && rst_n;
  assign out_chan.valid = valid_r[NUM_STAGES-1];

  // days and second of day
  e2u_day_split u_day_split (
    .clk           (clk),
    .stage_en      (stage_en),
    .epoch_seconds (in_chan.epoch_seconds),
    .days          (days),
    .sec_of_day    (sec_of_day)
  );

  // time of day
  e2u_clock u_clock (
    .clk              (clk),
    .stage_en         (stage_en),
    .sec_of_day       (sec_of_day),
    .second_of_minute (out_chan.second_of_minute),
    .minute_of_hour   (out_chan.minute_of_hour),
    .hour_of_day      (out_chan.hour_of_day)
  );

  // calendar date and weekday
  e2u_date u_date (
    .clk          (clk),
    .stage_en     (stage_en),
    .days         (days),
    .day_of_month (out_chan.day_of_month),
    .month_number (out_chan.month_number),
    .full_year    (out_chan.full_year),
    .weekday      (out_chan.weekday)
  );

`ifndef SYNTHESIS
  // an accepted transfer always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> valid_r[0])
    else $error("accepted transfer did not enter the pipeline");

  // a stage can only load when every stage before it can too
  a_en_order: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_en[NUM_STAGES-1:1] & ~stage_en[NUM_STAGES-2:0]) == '0)
    else $error("stage enables out of order, an item would be duplicated");

  // a stalled result must not be overwritten
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(out_chan.full_year)
      && $stable(out_chan.day_of_month) && $stable(out_chan.second_of_minute)))
    else $error("stalled result changed");

  // time fields in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.second_of_minute < 6'd60 &&
      out_chan.minute_of_hour < 6'd60 && out_chan.hour_of_day < 5'd24))
    else $error("time of day out of range");

  // date fields in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.month_number >= 4'd1 && out_chan.month_number <= 4'd12 &&
      out_chan.day_of_month >= 5'd1 && out_chan.weekday < 3'd7 &&
      out_chan.full_year >= 14'd1970 && out_chan.full_year <= 14'd9999))
    else $error("calendar date out of range");
`endif

endmodule
